@@ src/chs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and defaults of the connection hash set
package chs_pkg;

  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_ENTRIES = 1024;

  // width of the bucket generation mark
  localparam int GEN_W = 8;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // first field in the highest bits
  typedef struct packed {
    logic [31:0] socket_inode;
    logic [31:0] user_id;
    logic [15:0] remote_port;
    logic [31:0] remote_addr;
    logic [15:0] local_port;
    logic [31:0] local_addr;
  } rec_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } bkt_ctl_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ent_ctl_t;

endpackage

@@ src/chs_hash.sv @@
`timescale 1ns / 1ps
// bucket index unit: hash word reduced modulo the bucket count
module chs_hash import chs_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [31:0]                            h,
  output logic                                   done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        bucket <= BW'(h & 32'(BUCKETS - 1));
      end
    end
  end else begin : g_iter
    localparam int RW = $clog2(BUCKETS) + 1;

    logic          busy;
    logic [2:0]    cnt;
    logic [31:0]   shreg;
    logic [RW-1:0] rem;
    logic [RW-1:0] rem_next;

    // four remainder bits per cycle
    always_comb begin
      rem_next = rem;
      for (int k = 0; k < 4; k++) begin
        rem_next = {rem_next[RW-2:0], shreg[31-k]};
        if (rem_next >= RW'(BUCKETS)) begin
          rem_next = rem_next - RW'(BUCKETS);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        done <= 1'b0;
        cnt  <= '0;
      end else begin
        done <= 1'b0;
        if (start) begin
          busy  <= 1'b1;
          cnt   <= '0;
          shreg <= h;
          rem   <= '0;
        end else if (busy) begin
          rem   <= rem_next;
          shreg <= shreg << 4;
          cnt   <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end

    assign bucket = rem[BW-1:0];
  end

endmodule

@@ src/chs_bucket_store.sv @@
`timescale 1ns / 1ps
// bucket head memory with generation marks and clearing sweep
module chs_bucket_store import chs_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bkt_ctl_t                               ctl,
  input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] addr,
  input  logic [$clog2(ENTRIES)-1:0]             wr_head,
  output logic                                   busy,
  output logic                                   used,
  output logic [$clog2(ENTRIES)-1:0]             head
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int HW = $clog2(ENTRIES);

  logic [GEN_W+HW-1:0] mem [BUCKETS];
  logic [GEN_W-1:0]    gen;
  logic [GEN_W-1:0]    rd_gen;
  logic [BW-1:0]       sweep_addr;

  // stored generation zero never matches, live generations run from one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
      gen        <= GEN_W'(1);
    end else if (busy) begin
      sweep_addr <= sweep_addr + BW'(1);
      if (sweep_addr == BW'(BUCKETS - 1)) begin
        busy <= 1'b0;
      end
    end else if (ctl.clear) begin
      if (gen == '1) begin
        busy       <= 1'b1;
        sweep_addr <= '0;
        gen        <= GEN_W'(1);
      end else begin
        gen <= gen + GEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= {gen, wr_head};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      {rd_gen, head} <= mem[addr];
    end
  end

  assign used = (rd_gen == gen);

endmodule

@@ src/chs_entry_store.sv @@
`timescale 1ns / 1ps
// entry pool memory with record compare on the read side
module chs_entry_store import chs_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                         clk,
  input  ent_ctl_t                     ctl,
  input  logic [$clog2(ENTRIES)-1:0]   addr,
  input  rec_t                         rec,
  input  logic [$clog2(ENTRIES+1)-1:0] wr_link,
  output logic                         match,
  output logic [$clog2(ENTRIES+1)-1:0] link
);

  localparam int LW = $clog2(ENTRIES + 1);
  localparam int RECW = $bits(rec_t);

  logic [LW+RECW-1:0] mem [ENTRIES];
  rec_t               rd_rec;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= {wr_link, rec};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      {link, rd_rec} <= mem[addr];
    end
  end

  assign match = (rd_rec == rec);

endmodule

@@ src/connection_hash_set_unit.sv @@
`timescale 1ns / 1ps
// insert goes hash, bucket, response; lookup adds a chain walk before the response; clear goes clear, response
// power-of-two BUCKETS hash by masking, other BUCKETS add modulo iteration to insert and lookup
// one item at a time: the next transfer is taken only once the result has been registered
// the lookup chain walk reads the entry memory at one entry per cycle
// reset and every 255th clear sweep the bucket memory, s_tready low during the sweep
// the entry pool needs no sweep, the fill count resets to zero
module connection_hash_set_unit import chs_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // local_addr, local_port, remote_addr, remote_port, user_id, socket_inode
  input  logic [159:0] s_tdata,
  // action
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found, pool_full, zero fill
  output logic [7:0]   m_tdata
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int HW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_BKT   = 6'b000100,
    S_WALK  = 6'b001000,
    S_CLEAR = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t      state;
  logic [1:0]  action;
  rec_t        rec;
  rec_t        in_rec;
  logic [LW-1:0] fill;
  logic [BW-1:0] bkt;
  logic        res_found;
  logic        res_full;
  logic        accept;
  logic [31:0] hval;
  logic        hash_start;
  logic        hash_done;
  logic [BW-1:0] hash_bkt;
  bkt_ctl_t    bctl;
  ent_ctl_t    ectl;
  logic [BW-1:0] baddr;
  logic [HW-1:0] eaddr;
  logic [LW-1:0] ent_link_wr;
  logic        bbusy;
  logic        bused;
  logic [HW-1:0] bhead;
  logic        ematch;
  logic [LW-1:0] elink;

  assign in_rec = rec_t'(s_tdata);
  assign hval = in_rec.local_addr ^ {16'd0, in_rec.local_port} ^ in_rec.remote_addr
              ^ {16'd0, in_rec.remote_port} ^ in_rec.user_id ^ in_rec.socket_inode;

  assign s_tready = (state == S_IDLE) && !bbusy;
  assign accept = s_tvalid && s_tready;

  assign hash_start = accept && (((s_tuser == ACT_INSERT) && (fill < LW'(ENTRIES)))
                      || (s_tuser == ACT_LOOKUP));

  assign bctl.clear = accept && (s_tuser == ACT_CLEAR);
  assign bctl.rd = (state == S_HASH) && hash_done;
  assign bctl.wr = (state == S_BKT) && (action == ACT_INSERT);
  assign baddr = (state == S_HASH) ? hash_bkt : bkt;

  assign ectl.wr = (state == S_BKT) && (action == ACT_INSERT);
  assign ectl.rd = ((state == S_BKT) && (action == ACT_LOOKUP) && bused)
                || ((state == S_WALK) && !ematch && (elink != LW'(ENTRIES)));
  assign ent_link_wr = bused ? LW'(bhead) : LW'(ENTRIES);

  always_comb begin
    priority if ((state == S_BKT) && (action == ACT_INSERT)) begin
      eaddr = fill[HW-1:0];
    end else if (state == S_BKT) begin
      eaddr = bhead;
    end else begin
      eaddr = elink[HW-1:0];
    end
  end

  chs_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .h      (hval),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  chs_bucket_store #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_bucket (
    .clk     (clk),
    .rst     (rst),
    .ctl     (bctl),
    .addr    (baddr),
    .wr_head (fill[HW-1:0]),
    .busy    (bbusy),
    .used    (bused),
    .head    (bhead)
  );

  chs_entry_store #(
    .ENTRIES (ENTRIES)
  ) u_entry (
    .clk     (clk),
    .ctl     (ectl),
    .addr    (eaddr),
    .rec     (rec),
    .wr_link (ent_link_wr),
    .match   (ematch),
    .link    (elink)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            action    <= s_tuser;
            rec       <= in_rec;
            res_found <= 1'b0;
            res_full  <= (s_tuser == ACT_INSERT) && (fill >= LW'(ENTRIES));
            priority if (s_tuser == ACT_INSERT) begin
              if (fill >= LW'(ENTRIES)) begin
                state <= S_RESP;
              end else begin
                state <= S_HASH;
              end
            end else if (s_tuser == ACT_LOOKUP) begin
              state <= S_HASH;
            end else if (s_tuser == ACT_CLEAR) begin
              fill  <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt   <= hash_bkt;
            state <= S_BKT;
          end
        end
        S_BKT: begin
          if (action == ACT_INSERT) begin
            fill  <= fill + LW'(1);
            state <= S_RESP;
          end else if (bused) begin
            state <= S_WALK;
          end else begin
            state <= S_RESP;
          end
        end
        S_WALK: begin
          if (ematch) begin
            res_found <= 1'b1;
            state     <= S_RESP;
          end else if (elink == LW'(ENTRIES)) begin
            state <= S_RESP;
          end
        end
        S_CLEAR: begin
          if (!bbusy) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_full, res_found};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(ENTRIES))
    else $error("fill count beyond pool size");

  a_clear_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == ACT_CLEAR)) |=> (fill == '0))
    else $error("clear did not reset the pool");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && res_full) |-> (fill == LW'(ENTRIES)))
    else $error("pool full flagged with free entries");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    bbusy |-> !s_tready)
    else $error("transfer accepted during bucket sweep");

endmodule

@@ dv/connection_hash_set_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the connection hash set: directed table, then randomized rounds
module connection_hash_set_unit_tb;
  import chs_pkg::*;

  localparam int BUCKETS = DEF_BUCKETS;
  localparam int ENTRIES = DEF_ENTRIES;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOWN_FAILURES = 10;

  typedef struct packed {
    logic found;
    logic pool_full;
  } outcome_t;

  typedef struct {
    logic [1:0] act;
    rec_t       r;
    bit         typed;
    logic       found;
    logic       full;
  } row_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [1:0]   s_tuser = ACT_INSERT;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  connection_hash_set_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // shadow copy of the table
  bit          shadow_used [BUCKETS];
  int unsigned shadow_head [BUCKETS];
  rec_t        shadow_rec  [ENTRIES];
  int unsigned shadow_link [ENTRIES];
  int unsigned shadow_fill = 0;

  outcome_t expected_outcomes [$];
  rec_t     inserted_recs [$];
  row_t     directed_rows [$];
  int       fail_count = 0;
  bit       quiet = 1'b0;
  logic     hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_cnt = 0;

  logic [9:0] hot_bucket [8] = '{10'd0, 10'd1, 10'd2, 10'd341, 10'd512, 10'd777, 10'd1022,
                                 10'd1023};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("connection_hash_set_unit: mismatch");
    $finish;
  end

  function automatic int unsigned bucket_of(input rec_t r);
    logic [31:0] h;
    h = r.local_addr ^ {16'h0, r.local_port} ^ r.remote_addr ^ {16'h0, r.remote_port}
        ^ r.user_id ^ r.socket_inode;
    return h % BUCKETS;
  endfunction

  function automatic outcome_t hash_set_apply(input logic [1:0] act, input rec_t r);
    outcome_t    o;
    int unsigned b;
    int unsigned e;
    int unsigned steps;
    o = '0;
    b = bucket_of(r);
    case (act)
      ACT_INSERT: begin
        if (shadow_fill >= ENTRIES) begin
          o.pool_full = 1'b1;
        end else begin
          e = shadow_fill;
          shadow_rec[e] = r;
          shadow_link[e] = shadow_used[b] ? shadow_head[b] : ENTRIES;
          shadow_head[b] = e;
          shadow_used[b] = 1'b1;
          shadow_fill = e + 1;
        end
      end
      ACT_LOOKUP: begin
        if (shadow_used[b]) begin
          e = shadow_head[b];
          steps = 0;
          while (e < ENTRIES && steps < ENTRIES && !o.found) begin
            if (shadow_rec[e] == r) o.found = 1'b1;
            else e = shadow_link[e];
            steps++;
          end
        end
      end
      ACT_CLEAR: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // random record, optionally steered into one of a few crowded buckets
  function automatic rec_t fresh_rec(input bit pinned);
    rec_t        r;
    logic [31:0] h;
    r.local_addr   = $urandom;
    r.local_port   = 16'($urandom);
    r.remote_addr  = $urandom;
    r.remote_port  = 16'($urandom);
    r.user_id      = $urandom;
    r.socket_inode = $urandom;
    if (pinned) begin
      h = bucket_of(r);
      r.socket_inode[9:0] = r.socket_inode[9:0] ^ h[9:0]
                            ^ hot_bucket[3'($urandom_range(7))];
    end
    return r;
  endfunction

  task automatic report_failure(input string msg);
    if (fail_count < SHOWN_FAILURES) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic send_item(input logic [1:0] act, input rec_t r, input bit typed,
                           input logic exp_found, input logic exp_full);
    outcome_t want;
    while (!quiet && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = hash_set_apply(act, r);
    if (typed) begin
      want.found     = exp_found;
      want.pool_full = exp_full;
    end
    expected_outcomes.push_back(want);
  endtask

  task automatic random_op(input int insert_pct);
    int   pick;
    rec_t r;
    pick = $urandom_range(99);
    if (pick < insert_pct) begin
      if (inserted_recs.size() != 0 && $urandom_range(9) == 0)
        r = inserted_recs[$urandom_range(inserted_recs.size() - 1)];
      else
        r = fresh_rec($urandom_range(2) == 0);
      inserted_recs.push_back(r);
      if (inserted_recs.size() > 256) void'(inserted_recs.pop_front());
      send_item(ACT_INSERT, r, 1'b0, 1'b0, 1'b0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 5 || inserted_recs.size() == 0) begin
        send_item(ACT_SPARE, fresh_rec(1'b0), 1'b0, 1'b0, 1'b0);
      end else if (pick < 60) begin
        r = inserted_recs[$urandom_range(inserted_recs.size() - 1)];
        send_item(ACT_LOOKUP, r, 1'b0, 1'b0, 1'b0);
      end else if (pick < 90) begin
        r = inserted_recs[$urandom_range(inserted_recs.size() - 1)];
        r = r ^ (160'b1 << $urandom_range(159));
        send_item(ACT_LOOKUP, r, 1'b0, 1'b0, 1'b0);
      end else begin
        send_item(ACT_LOOKUP, fresh_rec($urandom_range(1) == 0), 1'b0, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic add_row(input logic [1:0] act, input rec_t r, input bit typed,
                         input logic found, input logic full);
    row_t row;
    row.act   = act;
    row.r     = r;
    row.typed = typed;
    row.found = found;
    row.full  = full;
    directed_rows.push_back(row);
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outcomes.size() == 0) begin
        report_failure($sformatf("result with nothing expected, tdata %h", m_tdata));
      end else begin
        want = expected_outcomes.pop_front();
        if (m_tdata[0] !== want.found)
          report_failure($sformatf("found: expected %b, got %b", want.found, m_tdata[0]));
        if (m_tdata[1] !== want.pool_full)
          report_failure($sformatf("pool_full: expected %b, got %b", want.pool_full,
                                   m_tdata[1]));
      end
    end
  end

  initial begin : stimulus
    rec_t zeros;
    rec_t ones;
    rec_t rec_a;
    rec_t rec_b;
    rec_t rec_c;
    rec_t probe;
    int   n;

    zeros = '0;
    ones  = '1;
    rec_a = fresh_rec(1'b1);
    rec_b = fresh_rec(1'b0);
    rec_b.socket_inode[9:0] = rec_b.socket_inode[9:0] ^ 10'(bucket_of(rec_b))
                              ^ 10'(bucket_of(rec_a));
    rec_c = fresh_rec(1'b0);
    rec_c.socket_inode[9:0] = rec_c.socket_inode[9:0] ^ 10'(bucket_of(rec_c))
                              ^ 10'(bucket_of(rec_a));

    add_row(ACT_LOOKUP, zeros, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, ones,  1'b1, 1'b0, 1'b0);
    add_row(ACT_SPARE,  ones,  1'b1, 1'b0, 1'b0);
    add_row(ACT_CLEAR,  zeros, 1'b1, 1'b0, 1'b0);
    add_row(ACT_INSERT, zeros, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, zeros, 1'b1, 1'b1, 1'b0);
    add_row(ACT_INSERT, ones,  1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, ones,  1'b1, 1'b1, 1'b0);
    probe = ones;
    probe.local_addr[0] = 1'b0;
    add_row(ACT_LOOKUP, probe, 1'b0, 1'b0, 1'b0);
    // a and b share a bucket, a twice in its chain
    add_row(ACT_INSERT, rec_a, 1'b1, 1'b0, 1'b0);
    add_row(ACT_INSERT, rec_b, 1'b1, 1'b0, 1'b0);
    add_row(ACT_INSERT, rec_a, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, rec_a, 1'b1, 1'b1, 1'b0);
    add_row(ACT_LOOKUP, rec_b, 1'b1, 1'b1, 1'b0);
    probe = rec_a;
    probe.remote_port = ~probe.remote_port;
    add_row(ACT_LOOKUP, probe, 1'b0, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, rec_c, 1'b0, 1'b0, 1'b0);
    add_row(ACT_SPARE,  zeros, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, rec_a, 1'b1, 1'b1, 1'b0);
    add_row(ACT_CLEAR,  ones,  1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, rec_a, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, zeros, 1'b1, 1'b0, 1'b0);
    add_row(ACT_INSERT, rec_b, 1'b1, 1'b0, 1'b0);
    add_row(ACT_LOOKUP, rec_b, 1'b1, 1'b1, 1'b0);
    add_row(ACT_LOOKUP, rec_a, 1'b0, 1'b0, 1'b0);
    add_row(ACT_CLEAR,  zeros, 1'b1, 1'b0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].r, directed_rows[i].typed,
                directed_rows[i].found, directed_rows[i].full);

    repeat (60) random_op(45);

    // fill the pool to exhaustion, then keep pushing refused inserts
    send_item(ACT_CLEAR, fresh_rec(1'b0), 1'b0, 1'b0, 1'b0);
    n = 0;
    while (shadow_fill < ENTRIES) begin
      if (n == 300) hold_req <= 1'b1;
      quiet = (n >= 500 && n < 800);
      random_op(95);
      n++;
    end
    quiet = 1'b0;
    repeat (30) random_op(80);

    // many clears, enough to wrap the bucket generation mark
    repeat (256) begin
      send_item(ACT_CLEAR, fresh_rec(1'b0), 1'b0, 1'b0, 1'b0);
      repeat ($urandom_range(2)) random_op(50);
    end

    s_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("connection_hash_set_unit: match");
    end else begin
      $display("connection_hash_set_unit: mismatch");
    end
    $finish;
  end

endmodule
